[design/cbm_pkg.sv]
package cbm_pkg;

	// Kinds of input word.
	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_WRITE   = 2'd1,
		CMD_CPU_MAP = 2'd2,
		CMD_PPU_MAP = 2'd3
	} cmd_t;

	// Memories that a mapped address can land in.
	typedef enum logic [1:0] {
		TGT_NONE      = 2'd0,
		TGT_PRG_ROM   = 2'd1,
		TGT_CHR_RAM   = 2'd2,
		TGT_NAMETABLE = 2'd3
	} target_t;

	// Nametable arrangements.
	typedef enum logic [1:0] {
		MIRROR_SINGLE0    = 2'd0,
		MIRROR_SINGLE1    = 2'd1,
		MIRROR_VERTICAL   = 2'd2,
		MIRROR_HORIZONTAL = 2'd3
	} mirror_t;

	// Widths of the word fields.
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned OFFSET_W = 18;
	localparam int unsigned PRG_BANK_W = 4;
	localparam int unsigned CHR_BANK_W = 2;

	// Register decode within the 0x4xxx page.
	localparam logic [3:0] REG_PAGE = 4'h4;
	localparam logic [11:0] REG_MIRROR_A = 12'h2FC;
	localparam logic [11:0] REG_MIRROR_B = 12'h2FD;
	localparam logic [11:0] REG_MIRROR_C = 12'h2FE;
	localparam logic [11:0] REG_MIRROR_D = 12'h3FE;
	localparam logic [11:0] REG_MIRROR_VH = 12'h2FF;
	localparam logic [11:0] REG_CNT_OFF = 12'h501;
	localparam logic [11:0] REG_CNT_LO = 12'h502;
	localparam logic [11:0] REG_CNT_HI = 12'h503;

	// Counter terminal value and the fixed upper PRG bank.
	localparam logic [15:0] CNT_MAX = 16'hFFFF;
	localparam logic [PRG_BANK_W-1:0] FIXED_PRG_BANK = 4'd7;

	// Palette page of the PPU space, which is not mapped.
	localparam logic [5:0] PALETTE_PAGE = 6'h3F;

endpackage

[design/cartridge_bank_mapper_irq.sv]
// Cartridge bank mapper with a CPU-cycle interrupt counter.
// Input channel (item_valid / item_stall): one word per CPU bus event, carrying
// cmd, addr and data. A cycle tick advances the interrupt counter, a CPU write
// updates the mirroring, counter or bank registers, and the two map commands
// translate a CPU or PPU address into a PRG ROM, CHR RAM or nametable offset.
// Output channel (result_valid / result_stall): exactly one result word per
// input word, in order, giving the IRQ line level after that word, the target
// memory and the byte offset within it.
// A word accepted into the input register is processed by the decode and
// mapping logic and then loaded into the result register. Throughput is one
// word per cycle while the receiver does not stall, set by the single pass
// through the decode logic between the two registers.
// When the receiver stalls, the result register holds its word and the input
// register can still take one further word; after that item_stall rises.
// Reset clears both pipeline stages and all mapper state: banks zero,
// single-screen page 0, counter zero and disabled, IRQ not asserted.
module cartridge_bank_mapper_irq
	import cbm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [1:0]          cmd,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [DATA_W-1:0]   data,
	output logic                result_valid,
	input  logic                result_stall,
	output logic                irq_asserted,
	output logic [1:0]          target,
	output logic [OFFSET_W-1:0] mapped_offset
);

	// Pipeline registers.
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [DATA_W-1:0]   data_s1;
	logic                valid_s2;
	logic                irq_s2;
	target_t             target_s2;
	logic [OFFSET_W-1:0] offset_s2;

	// Mapper state.
	logic [PRG_BANK_W-1:0] prg_bank_q;
	logic [CHR_BANK_W-1:0] chr_bank_q;
	mirror_t               mirror_q;
	logic                  count_en_q;
	logic [15:0]           counter_q;
	logic                  irq_q;

	// Next-state and result values.
	logic [PRG_BANK_W-1:0] prg_bank_d;
	logic [CHR_BANK_W-1:0] chr_bank_d;
	mirror_t               mirror_d;
	logic                  count_en_d;
	logic [15:0]           counter_d;
	logic                  irq_d;
	target_t               target_d;
	logic [OFFSET_W-1:0]   offset_d;
	logic                  page;
	logic                  adv_s2;
	logic                  adv_s1;

	// Flow control: the result register loads when empty or being taken.
	assign adv_s2 = !valid_s2 || !result_stall;
	assign adv_s1 = valid_s1 && adv_s2;
	assign item_stall = valid_s1 && !adv_s2;

	// Decode the word in the input register against the current state.
	always_comb begin
		prg_bank_d = prg_bank_q;
		chr_bank_d = chr_bank_q;
		mirror_d = mirror_q;
		count_en_d = count_en_q;
		counter_d = counter_q;
		irq_d = irq_q;
		target_d = TGT_NONE;
		offset_d = '0;
		page = 1'b0;
		case (cmd_s1)
			CMD_TICK: begin
				if (count_en_q && (counter_q != '0)) begin
					if (counter_q == CNT_MAX) begin
						irq_d = 1'b1;
					end
					counter_d = counter_q + 16'd1;
				end
			end
			CMD_WRITE: begin
				if (addr_s1[15]) begin
					prg_bank_d = data_s1[5:2];
					chr_bank_d = data_s1[1:0];
				end else if (addr_s1[15:12] == REG_PAGE) begin
					case (addr_s1[11:0])
						REG_MIRROR_A, REG_MIRROR_B, REG_MIRROR_C, REG_MIRROR_D: begin
							mirror_d = data_s1[4] ? MIRROR_SINGLE1 : MIRROR_SINGLE0;
						end
						REG_MIRROR_VH: begin
							mirror_d = data_s1[4] ? MIRROR_HORIZONTAL : MIRROR_VERTICAL;
						end
						REG_CNT_OFF: begin
							count_en_d = 1'b0;
						end
						REG_CNT_LO: begin
							counter_d = {counter_q[15:8], data_s1};
							irq_d = 1'b0;
						end
						REG_CNT_HI: begin
							counter_d = {data_s1, counter_q[7:0]};
							count_en_d = 1'b1;
							irq_d = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			CMD_CPU_MAP: begin
				if (addr_s1[15:14] == 2'b11) begin
					target_d = TGT_PRG_ROM;
					offset_d = {FIXED_PRG_BANK, addr_s1[13:0]};
				end else if (addr_s1[15]) begin
					target_d = TGT_PRG_ROM;
					offset_d = {prg_bank_q, addr_s1[13:0]};
				end
			end
			CMD_PPU_MAP: begin
				if (!addr_s1[13]) begin
					target_d = TGT_CHR_RAM;
					offset_d = {3'd0, chr_bank_q, addr_s1[12:0]};
				end else if (addr_s1[13:8] != PALETTE_PAGE) begin
					case (mirror_q)
						MIRROR_SINGLE0:    page = 1'b0;
						MIRROR_SINGLE1:    page = 1'b1;
						MIRROR_VERTICAL:   page = addr_s1[10];
						MIRROR_HORIZONTAL: page = addr_s1[11];
						default:           page = 1'b0;
					endcase
					target_d = TGT_NAMETABLE;
					offset_d = {7'd0, page, addr_s1[9:0]};
				end
			end
			default: begin
			end
		endcase
	end

	// Valid bits of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			cmd_s1 <= cmd_t'(cmd);
			addr_s1 <= addr;
			data_s1 <= data;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			irq_s2 <= irq_d;
			target_s2 <= target_d;
			offset_s2 <= offset_d;
		end
	end

	// Mapper state changes once per word as it leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_q <= '0;
			chr_bank_q <= '0;
			mirror_q <= MIRROR_SINGLE0;
			count_en_q <= 1'b0;
			counter_q <= '0;
			irq_q <= 1'b0;
		end else if (adv_s1) begin
			prg_bank_q <= prg_bank_d;
			chr_bank_q <= chr_bank_d;
			mirror_q <= mirror_d;
			count_en_q <= count_en_d;
			counter_q <= counter_d;
			irq_q <= irq_d;
		end
	end

	assign result_valid = valid_s2;
	assign irq_asserted = irq_s2;
	assign target = target_s2;
	assign mapped_offset = offset_s2;

endmodule

[design/cbm_checker.sv]
module cbm_checker
	import cbm_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_stall,
	input logic                irq_asserted,
	input logic [1:0]          target,
	input logic [OFFSET_W-1:0] mapped_offset
);

	// A stalled result word stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(irq_asserted)
			&& $stable(target) && $stable(mapped_offset))
		else $error("result word changed while stalled");

	// Unmapped results carry a zero offset.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (target == TGT_NONE) |-> mapped_offset == '0)
		else $error("unmapped result with nonzero offset");

	// Nametable offsets stay within the 2 KiB of nametable RAM.
	a_nt_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (target == TGT_NAMETABLE) |-> mapped_offset[17:11] == '0)
		else $error("nametable offset out of range");

	// CHR offsets stay within four 8 KiB banks.
	a_chr_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (target == TGT_CHR_RAM) |-> mapped_offset[17:15] == '0)
		else $error("CHR offset out of range");

endmodule

bind cartridge_bank_mapper_irq cbm_checker u_cbm_checker (.*);

[bench/cartridge_bank_mapper_irq_checker.sv]
// Watches both channels of the mapper, keeps its own copy of the mapper state and
// compares every result word with the word it predicts.
module cartridge_bank_mapper_irq_checker
	import cbm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  logic [1:0]          cmd,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [DATA_W-1:0]   data,
	input  logic                result_valid,
	input  logic                result_stall,
	input  logic                irq_asserted,
	input  logic [1:0]          target,
	input  logic [OFFSET_W-1:0] mapped_offset,
	output int                  errors,
	output int                  pending,
	output int                  checked,
	output int                  wraps
);

	typedef struct packed {
		logic                irq;
		target_t             tgt;
		logic [OFFSET_W-1:0] offset;
	} bus_result_t;

	// Shadow copy of the mapper registers.
	logic [PRG_BANK_W-1:0] prg_sel;
	logic [CHR_BANK_W-1:0] chr_sel;
	mirror_t               mirror;
	logic                  count_on;
	logic [15:0]           irq_count;
	logic                  irq_level;

	bus_result_t expected_results[$];
	int          fail_count;
	int          match_count;
	int          wrap_count;

	// Applies one input word to the shadow state and works out the result it gives.
	task automatic apply_bus_word(input cmd_t c, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d, output bus_result_t r);
		logic [13:0]           ppu_a;
		logic [PRG_BANK_W-1:0] bank;
		logic                  page;
		r.tgt = TGT_NONE;
		r.offset = '0;
		ppu_a = a[13:0];
		page = 1'b0;
		case (c)
		CMD_TICK: begin
			// The counter only moves while enabled and nonzero; passing the top wraps it to zero.
			if (count_on && irq_count != 16'd0) begin
				if (irq_count == CNT_MAX) begin
					irq_level = 1'b1;
					wrap_count++;
				end
				irq_count = irq_count + 16'd1;
			end
		end
		CMD_WRITE: begin
			if (a[15]) begin
				prg_sel = d[5:2];
				chr_sel = d[1:0];
			end else if (a[15:12] == REG_PAGE) begin
				case (a[11:0])
				REG_MIRROR_A, REG_MIRROR_B, REG_MIRROR_C, REG_MIRROR_D: begin
					mirror = d[4] ? MIRROR_SINGLE1 : MIRROR_SINGLE0;
				end
				REG_MIRROR_VH: begin
					mirror = d[4] ? MIRROR_HORIZONTAL : MIRROR_VERTICAL;
				end
				REG_CNT_OFF: begin
					count_on = 1'b0;
				end
				REG_CNT_LO: begin
					irq_count[7:0] = d;
					irq_level = 1'b0;
				end
				REG_CNT_HI: begin
					irq_count[15:8] = d;
					count_on = 1'b1;
					irq_level = 1'b0;
				end
				default: begin
				end
				endcase
			end
		end
		CMD_CPU_MAP: begin
			// The upper 16 KiB window is always the fixed bank.
			if (a[15]) begin
				bank = a[14] ? FIXED_PRG_BANK : prg_sel;
				r.tgt = TGT_PRG_ROM;
				r.offset = {bank, a[13:0]};
			end
		end
		default: begin
			// PPU space wraps at 16 KiB; the palette page is left unmapped.
			if (!ppu_a[13]) begin
				r.tgt = TGT_CHR_RAM;
				r.offset = {3'b000, chr_sel, ppu_a[12:0]};
			end else if (ppu_a[13:8] != PALETTE_PAGE) begin
				case (mirror)
				MIRROR_SINGLE0: page = 1'b0;
				MIRROR_SINGLE1: page = 1'b1;
				MIRROR_VERTICAL: page = ppu_a[10];
				default: page = ppu_a[11];
				endcase
				r.tgt = TGT_NAMETABLE;
				r.offset = {7'b0000000, page, ppu_a[9:0]};
			end
		end
		endcase
		r.irq = irq_level;
	endtask

	// Predict on each accepted input word, then check each accepted result word.
	always @(posedge clk or negedge arst_n) begin
		bus_result_t want;
		bus_result_t got;
		if (!arst_n) begin
			prg_sel = '0;
			chr_sel = '0;
			mirror = MIRROR_SINGLE0;
			count_on = 1'b0;
			irq_count = '0;
			irq_level = 1'b0;
			expected_results.delete();
			fail_count = 0;
			match_count = 0;
			wrap_count = 0;
		end else begin
			if (item_valid && !item_stall) begin
				apply_bus_word(cmd_t'(cmd), addr, data, want);
				expected_results.push_back(want);
			end
			if (result_valid && !result_stall) begin
				got.irq = irq_asserted;
				got.tgt = target_t'(target);
				got.offset = mapped_offset;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result word with nothing expected: irq %b target %0d offset %h",
							got.irq, got.tgt, got.offset);
				end else begin
					want = expected_results.pop_front();
					if (got.irq !== want.irq || got.tgt !== want.tgt
							|| got.offset !== want.offset) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected irq %b target %0d offset %h, got irq %b target %0d offset %h",
								want.irq, want.tgt, want.offset, got.irq, got.tgt, got.offset);
					end else begin
						match_count++;
					end
				end
			end
		end
		errors <= fail_count;
		pending <= expected_results.size();
		checked <= match_count;
		wraps <= wrap_count;
	end

endmodule

[bench/tb_cartridge_bank_mapper_irq.sv]
module tb_cartridge_bank_mapper_irq;
	import cbm_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	logic [1:0]          cmd = CMD_TICK;
	logic [ADDR_W-1:0]   addr = '0;
	logic [DATA_W-1:0]   data = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic                irq_asserted;
	logic [1:0]          target;
	logic [OFFSET_W-1:0] mapped_offset;

	int errors;
	int pending;
	int checked;
	int wraps;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_ticket = 0;
	int words_sent = 0;

	cartridge_bank_mapper_irq dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.cmd(cmd), .addr(addr), .data(data),
		.result_valid(result_valid), .result_stall(result_stall),
		.irq_asserted(irq_asserted), .target(target), .mapped_offset(mapped_offset)
	);

	cartridge_bank_mapper_irq_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.cmd(cmd), .addr(addr), .data(data),
		.result_valid(result_valid), .result_stall(result_stall),
		.irq_asserted(irq_asserted), .target(target), .mapped_offset(mapped_offset),
		.errors(errors), .pending(pending), .checked(checked), .wraps(wraps)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [31:0] r;
		r = $urandom;
		return r[ADDR_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] rand_data();
		logic [31:0] r;
		r = $urandom;
		return r[DATA_W-1:0];
	endfunction

	// Write addresses weighted towards the decoded registers and their near misses.
	function automatic logic [ADDR_W-1:0] pick_write_addr();
		logic [31:0] r;
		r = $urandom;
		case (r[3:0])
		4'd0: return {REG_PAGE, REG_MIRROR_A};
		4'd1: return {REG_PAGE, REG_MIRROR_B};
		4'd2: return {REG_PAGE, REG_MIRROR_C};
		4'd3: return {REG_PAGE, REG_MIRROR_D};
		4'd4: return {REG_PAGE, REG_MIRROR_VH};
		4'd5: return {REG_PAGE, REG_CNT_OFF};
		4'd6: return {REG_PAGE, REG_CNT_LO};
		4'd7: return {REG_PAGE, REG_CNT_HI};
		// The register just below the counter-disable one is not decoded.
		4'd8: return {REG_PAGE, REG_CNT_OFF - 12'd1};
		// The APU and I/O range is passed elsewhere and so ignored here.
		4'd9: return 16'h4000 + {11'd0, r[8:4]};
		4'd10, 4'd11: return {1'b1, r[30:16]};
		default: return r[31:16];
		endcase
	endfunction

	// Offers one word and returns once it has been accepted.
	task automatic send_word(input cmd_t c, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			addr <= rand_addr();
			data <= rand_data();
			@(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= c;
		addr <= a;
		data <= d;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// Loads the counter near its top and runs ticks through the wrap, with some noise.
	task automatic run_counter_sequence();
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		int                n;
		lo = ($urandom_range(3) == 0) ? rand_data() : DATA_W'($urandom_range(192, 255));
		hi = ($urandom_range(3) == 0) ? rand_data() : 8'hFF;
		n = $urandom_range(1, 80);
		if ($urandom_range(1) == 0)
			send_word(CMD_WRITE, {REG_PAGE, REG_CNT_LO}, lo);
		send_word(CMD_WRITE, {REG_PAGE, REG_CNT_HI}, hi);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(15))
			0: send_word(CMD_CPU_MAP, rand_addr(), rand_data());
			1: send_word(CMD_PPU_MAP, rand_addr(), rand_data());
			2: send_word(CMD_WRITE, pick_write_addr(), rand_data());
			default: send_word(CMD_TICK, rand_addr(), rand_data());
			endcase
		end
	endtask

	// Mixed random traffic until the word count reaches the given mark.
	task automatic run_random_until(input int mark);
		logic [31:0] r;
		int          n;
		while (words_sent < mark) begin
			r = $urandom;
			case (r[3:0])
			4'd0, 4'd1, 4'd2, 4'd3: run_counter_sequence();
			4'd4, 4'd5: send_word(CMD_WRITE, pick_write_addr(), rand_data());
			4'd6: send_word(CMD_CPU_MAP, rand_addr(), rand_data());
			4'd7: send_word(CMD_PPU_MAP, rand_addr(), rand_data());
			4'd8, 4'd9: begin
				// New banks, then a few maps through them.
				send_word(CMD_WRITE, {1'b1, r[30:16]}, rand_data());
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					send_word(($urandom_range(1) == 0) ? CMD_CPU_MAP : CMD_PPU_MAP,
						rand_addr(), rand_data());
			end
			4'd10, 4'd11: begin
				// A write that may change the mirroring, then nametable maps.
				send_word(CMD_WRITE, pick_write_addr(), rand_data());
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					send_word(CMD_PPU_MAP, 16'h2000 | (rand_addr() & 16'h1FFF),
						rand_data());
			end
			4'd12: begin
				n = $urandom_range(1, 20);
				for (int i = 0; i < n; i++)
					send_word(CMD_TICK, rand_addr(), rand_data());
			end
			default: send_word(cmd_t'(r[21:20]), r[31:16], r[29:22]);
			endcase
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin : receiver
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		forever begin
			@(posedge clk);
			if (hold_ticket != hold_served) begin
				hold_served = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Ends the run if nothing moves on either channel for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("no word moved for %0d cycles", STALL_LIMIT);
		$display("[cartridge_bank_mapper_irq] ERROR");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: map extremes at reset, banks, every mirroring mode,
		// ignored writes, and the counter running through its wrap.
		send_word(CMD_CPU_MAP, 16'h7FFF, 8'h00);
		send_word(CMD_CPU_MAP, 16'h8000, 8'hFF);
		send_word(CMD_CPU_MAP, 16'hFFFF, 8'h00);
		send_word(CMD_PPU_MAP, 16'h0000, 8'h00);
		send_word(CMD_PPU_MAP, 16'h2C00, 8'h00);
		send_word(CMD_PPU_MAP, 16'h3F00, 8'h00);
		send_word(CMD_PPU_MAP, 16'hFFFF, 8'h00);
		send_word(CMD_WRITE, 16'hFFFF, 8'hFF);
		send_word(CMD_CPU_MAP, 16'hBFFF, 8'h00);
		send_word(CMD_PPU_MAP, 16'h5FFF, 8'h00);
		send_word(CMD_WRITE, {REG_PAGE, REG_MIRROR_D}, 8'h10);
		send_word(CMD_PPU_MAP, 16'h3EFF, 8'h00);
		send_word(CMD_WRITE, {REG_PAGE, REG_MIRROR_VH}, 8'hEF);
		send_word(CMD_PPU_MAP, 16'h2400, 8'h00);
		send_word(CMD_WRITE, {REG_PAGE, REG_MIRROR_VH}, 8'h10);
		send_word(CMD_PPU_MAP, 16'h2800, 8'h00);
		send_word(CMD_WRITE, {REG_PAGE, REG_CNT_OFF - 12'd1}, 8'hFF);
		send_word(CMD_WRITE, 16'h4017, 8'hFF);
		send_word(CMD_WRITE, {REG_PAGE, REG_CNT_LO}, 8'hFE);
		send_word(CMD_WRITE, {REG_PAGE, REG_CNT_HI}, 8'hFF);
		send_word(CMD_TICK, 16'h0000, 8'h00);
		send_word(CMD_TICK, 16'hFFFF, 8'hFF);
		send_word(CMD_TICK, 16'h0000, 8'h00);
		send_word(CMD_WRITE, {REG_PAGE, REG_CNT_LO}, 8'h00);
		send_word(CMD_WRITE, {REG_PAGE, REG_CNT_OFF}, 8'h00);
		send_word(CMD_TICK, 16'h0000, 8'h00);

		// Random traffic in three idling phases; the last one carries the long hold-off.
		send_idle_pct = 35;
		recv_idle_pct <= 75;
		run_random_until(words_sent + 700);
		send_idle_pct = 75;
		recv_idle_pct <= 35;
		run_random_until(words_sent + 700);
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		hold_ticket <= hold_ticket + 1;
		run_random_until(words_sent + 600);
		item_valid <= 1'b0;

		// Drain the pipeline, then give it a few cycles for any stray word.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("sent %0d words across three idling phases and one long receiver hold-off",
			words_sent);
		$display("%0d result words matched, %0d counter wraps predicted", checked, wraps);
		if (errors == 0)
			$display("[cartridge_bank_mapper_irq] OK");
		else
			$display("[cartridge_bank_mapper_irq] ERROR");
		$finish;
	end

endmodule
